/* rtl/rvx_pkg.sv */
// Shared opcodes, result codes and the pipeline payload type of the RV32IM execute unit.
package rvx_pkg;

    // Major opcodes
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // Counter CSR windows
    localparam logic [11:0] CSR_CYC_LO  = 12'hc00;
    localparam logic [11:0] CSR_CYC_HI  = 12'hc02;
    localparam logic [11:0] CSR_CYCH_LO = 12'hc80;
    localparam logic [11:0] CSR_CYCH_HI = 12'hc82;

    // M extension funct3 codes
    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_DIV    = 3'd4;
    localparam logic [2:0] F3_DIVU   = 3'd5;
    localparam logic [2:0] F3_REM    = 3'd6;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_ILLEGAL = 2'd1;
    localparam logic [1:0] FAULT_ALIGN   = 2'd2;

    // Result source
    localparam logic [1:0] SEL_ALU = 2'd0;
    localparam logic [1:0] SEL_MUL = 2'd1;
    localparam logic [1:0] SEL_DIV = 2'd2;

    // Divider: DIV_STAGES stages of DIV_BITS quotient bits each
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = 32 / DIV_BITS;

    typedef struct packed {
        logic        rd_write;
        logic [4:0]  rd_index;
        logic [31:0] rd_value;
        logic [31:0] next_pc;
        logic [1:0]  mem_op;
        logic [1:0]  access_size;
        logic        load_unsigned;
        logic [31:0] mem_address;
        logic [31:0] store_data;
        logic [1:0]  fault;
        logic [1:0]  sel;
        logic [2:0]  f3;
        logic        neg_q;
        logic        neg_r;
        logic        div_zero;
    } t_item;

    typedef struct packed {
        logic [32:0] a;
        logic [32:0] b;
    } t_mul_ops;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] dvs;
    } t_div_state;

endpackage

/* rtl/rv32im_execute_unit.sv */
// Top level of the pipelined RV32IM execute unit.
// Accepts one instruction per clock unless stalled, and returns one result beat per
// instruction, in order. The pipeline depth is set by the divider, which resolves four
// quotient bits per stage over eight stages; the 33x33 multiplier runs as two partial
// products and a registered sum inside the divider's stages, and every other operation is
// resolved in the first stage and carried alongside. The whole pipeline holds while a result
// beat waits at the output under stall; bubbles do not collapse.
module rv32im_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instr,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_rs1_value,
    input  logic [31:0] i_rs2_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_rd_write,
    output logic [4:0]  o_rd_index,
    output logic [31:0] o_rd_value,
    output logic [31:0] o_next_pc,
    output logic [1:0]  o_mem_op,
    output logic [1:0]  o_access_size,
    output logic        o_load_unsigned,
    output logic [31:0] o_mem_address,
    output logic [31:0] o_store_data,
    output logic [1:0]  o_fault
);
    import rvx_pkg::*;

    logic       en;
    t_item      dec_item;
    t_mul_ops   dec_mul;
    t_div_state dec_div;

    t_item      r_p   [0:DIV_STAGES];
    t_div_state r_d   [0:DIV_STAGES];
    logic       r_v   [0:DIV_STAGES];
    t_div_state step_d[1:DIV_STAGES];
    t_mul_ops   r_mul;
    logic signed [49:0] r_pl, r_ph;
    logic signed [65:0] prod;
    t_item      mul_item;
    t_item      n_out, r_out;
    logic       r_ov;
    logic [31:0] q_fix, r_fix;

    // Advance everything unless the output beat is held
    assign en      = !(r_ov && i_stall);
    assign o_stall = r_ov && i_stall;

    rvx_decode u_decode (
        .i_instr     (i_instr),
        .i_pc        (i_pc),
        .i_rs1_value (i_rs1_value),
        .i_rs2_value (i_rs2_value),
        .o_item      (dec_item),
        .o_mul       (dec_mul),
        .o_div       (dec_div)
    );

    // Stage 0: capture decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
        end
        if (en) begin
            r_p[0] <= dec_item;
            r_d[0] <= dec_div;
            r_mul  <= dec_mul;
        end
    end

    // Multiplier partial products, one per half of b
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pl <= 50'($signed(r_mul.a) * $signed({1'b0, r_mul.b[15:0]}));
            r_ph <= 50'($signed(r_mul.a) * $signed(r_mul.b[32:16]));
        end
    end

    assign prod = 66'(r_pl) + (66'(r_ph) <<< 16);

    // Merge the product into the item bound for stage 2
    always_comb begin
        mul_item = r_p[1];
        if (r_p[1].sel == SEL_MUL) begin
            mul_item.rd_value = (r_p[1].f3 == F3_MUL) ? prod[31:0] : prod[63:32];
        end
    end

    // Divider stages; the product lands in stage 2
    genvar k;
    generate
        for (k = 1; k <= DIV_STAGES; k++) begin : g_stage
            rvx_div_step u_step (
                .i_state (r_d[k-1]),
                .o_state (step_d[k])
            );
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (en) begin
                    r_v[k] <= r_v[k-1];
                end
                if (en) begin
                    r_d[k] <= step_d[k];
                    if (k == 2) r_p[k] <= mul_item;
                    else r_p[k] <= r_p[k-1];
                end
            end
        end
    endgenerate

    // Final divide fix-up and output register
    assign q_fix = r_p[DIV_STAGES].neg_q ? (32'd0 - r_d[DIV_STAGES].quo)
                                         : r_d[DIV_STAGES].quo;
    assign r_fix = r_p[DIV_STAGES].neg_r ? (32'd0 - r_d[DIV_STAGES].rem)
                                         : r_d[DIV_STAGES].rem;

    always_comb begin
        n_out = r_p[DIV_STAGES];
        if (r_p[DIV_STAGES].sel == SEL_DIV) begin
            if (r_p[DIV_STAGES].div_zero) n_out.rd_value = '0;
            else if (r_p[DIV_STAGES].f3[1]) n_out.rd_value = r_fix;
            else n_out.rd_value = q_fix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_v[DIV_STAGES];
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid         = r_ov;
    assign o_rd_write      = r_out.rd_write;
    assign o_rd_index      = r_out.rd_index;
    assign o_rd_value      = r_out.rd_value;
    assign o_next_pc       = r_out.next_pc;
    assign o_mem_op        = r_out.mem_op;
    assign o_access_size   = r_out.access_size;
    assign o_load_unsigned = r_out.load_unsigned;
    assign o_mem_address   = r_out.mem_address;
    assign o_store_data    = r_out.store_data;
    assign o_fault         = r_out.fault;

    // Checks
    a_illegal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fault == FAULT_ILLEGAL) |-> (!o_rd_write && o_mem_op == MEM_NONE))
        else $error("illegal instruction result writes or accesses memory");

    a_align_no_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fault == FAULT_ALIGN) |-> (o_mem_op == MEM_NONE))
        else $error("misaligned access still issued");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input held while output is empty");

    a_last_stage_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[DIV_STAGES] && en) |=> o_valid)
        else $error("beat lost between last stage and output");

endmodule

/* rtl/rvx_decode.sv */
// Decode, immediates, ALU, branch and address logic; set-up of the multiply and divide operands.
module rvx_decode (
    input  logic [31:0]          i_instr,
    input  logic [31:0]          i_pc,
    input  logic [31:0]          i_rs1_value,
    input  logic [31:0]          i_rs2_value,
    output rvx_pkg::t_item       o_item,
    output rvx_pkg::t_mul_ops    o_mul,
    output rvx_pkg::t_div_state  o_div
);
    import rvx_pkg::*;

    logic [6:0]  opcode;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  shamt;
    logic [11:0] csr;
    logic [31:0] a, b;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u, seq;
    logic        illegal, take, sgn, sa, sb;
    t_item       it;

    assign opcode = i_instr[6:0];
    assign f3     = i_instr[14:12];
    assign f7     = i_instr[31:25];
    assign shamt  = i_instr[24:20];
    assign csr    = i_instr[31:20];
    assign a      = i_rs1_value;
    assign b      = i_rs2_value;

    // Immediates
    assign imm_i = {{20{i_instr[31]}}, i_instr[31:20]};
    assign imm_s = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign imm_b = {{19{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                    i_instr[11:8], 1'b0};
    assign imm_j = {{11{i_instr[31]}}, i_instr[31], i_instr[19:12], i_instr[20],
                    i_instr[30:21], 1'b0};
    assign imm_u = {i_instr[31:12], 12'h000};
    assign seq   = i_pc + 32'd4;

    // Decode all instructions and execute those that need neither the multiplier nor the divider
    always_comb begin
        it          = '0;
        it.rd_index = i_instr[11:7];
        it.next_pc  = seq;
        it.f3       = f3;
        illegal     = 1'b0;
        take        = 1'b0;
        unique case (opcode)
            OP_LUI: begin
                it.rd_write = 1'b1;
                it.rd_value = imm_u;
            end
            OP_AUIPC: begin
                it.rd_write = 1'b1;
                it.rd_value = i_pc + imm_u;
            end
            OP_JAL: begin
                it.rd_write = 1'b1;
                it.rd_value = seq;
                it.next_pc  = i_pc + imm_j;
            end
            OP_JALR: begin
                if (f3 != 3'd0) begin
                    illegal = 1'b1;
                end else begin
                    it.rd_write = 1'b1;
                    it.rd_value = seq;
                    it.next_pc  = (a + imm_i) & 32'hffff_fffe;
                end
            end
            OP_BRANCH: begin
                case (f3)
                    3'd0:    take = (a == b);
                    3'd1:    take = (a != b);
                    3'd4:    take = ($signed(a) < $signed(b));
                    3'd5:    take = !($signed(a) < $signed(b));
                    3'd6:    take = (a < b);
                    3'd7:    take = (a >= b);
                    default: illegal = 1'b1;
                endcase
                if (take) begin
                    it.next_pc = i_pc + imm_b;
                end
            end
            OP_LOAD: begin
                if (f3 == 3'd3 || f3 > 3'd5) begin
                    illegal = 1'b1;
                end else begin
                    it.mem_op        = MEM_LOAD;
                    it.access_size   = f3[1:0];
                    it.load_unsigned = f3[2];
                    it.mem_address   = a + imm_i;
                end
            end
            OP_STORE: begin
                if (f3 > 3'd2) begin
                    illegal = 1'b1;
                end else begin
                    it.mem_op      = MEM_STORE;
                    it.access_size = f3[1:0];
                    it.mem_address = a + imm_s;
                    it.store_data  = b;
                end
            end
            OP_IMM: begin
                it.rd_write = 1'b1;
                case (f3)
                    3'd0: it.rd_value = a + imm_i;
                    3'd2: it.rd_value = {31'd0, $signed(a) < $signed(imm_i)};
                    3'd3: it.rd_value = {31'd0, a < imm_i};
                    3'd4: it.rd_value = a ^ imm_i;
                    3'd6: it.rd_value = a | imm_i;
                    3'd7: it.rd_value = a & imm_i;
                    3'd1: begin
                        if (f7 != F7_BASE) illegal = 1'b1;
                        else it.rd_value = a << shamt;
                    end
                    default: begin
                        if (f7 == F7_BASE) it.rd_value = a >> shamt;
                        else if (f7 == F7_ALT) it.rd_value = 32'($signed(a) >>> shamt);
                        else illegal = 1'b1;
                    end
                endcase
            end
            OP_REG: begin
                it.rd_write = 1'b1;
                if (f7 == F7_MULDIV) begin
                    it.sel = f3[2] ? SEL_DIV : SEL_MUL;
                end else if (f7 == F7_ALT) begin
                    if (f3 == 3'd0) it.rd_value = a - b;
                    else if (f3 == 3'd5) it.rd_value = 32'($signed(a) >>> b[4:0]);
                    else illegal = 1'b1;
                end else if (f7 != F7_BASE) begin
                    illegal = 1'b1;
                end else begin
                    case (f3)
                        3'd0:    it.rd_value = a + b;
                        3'd1:    it.rd_value = a << b[4:0];
                        3'd2:    it.rd_value = {31'd0, $signed(a) < $signed(b)};
                        3'd3:    it.rd_value = {31'd0, a < b};
                        3'd4:    it.rd_value = a ^ b;
                        3'd5:    it.rd_value = a >> b[4:0];
                        3'd6:    it.rd_value = a | b;
                        default: it.rd_value = a & b;
                    endcase
                end
            end
            OP_SYSTEM: begin
                if (f3 == 3'd0) begin
                    illegal = 1'b0;
                end else if (f3 == 3'd2 &&
                             ((csr >= CSR_CYC_LO && csr <= CSR_CYC_HI) ||
                              (csr >= CSR_CYCH_LO && csr <= CSR_CYCH_HI))) begin
                    illegal = 1'b0;
                end else begin
                    illegal = 1'b1;
                end
            end
            default: illegal = 1'b1;
        endcase

        // Reject bad encodings, then misaligned accesses
        if (illegal) begin
            it          = '0;
            it.rd_index = i_instr[11:7];
            it.next_pc  = seq;
            it.fault    = FAULT_ILLEGAL;
        end else if (it.mem_op != MEM_NONE &&
                     ((it.access_size == SIZE_HALF && it.mem_address[0]) ||
                      (it.access_size == SIZE_WORD && it.mem_address[1:0] != 2'd0))) begin
            it.mem_op = MEM_NONE;
            it.fault  = FAULT_ALIGN;
        end
    end

    // Operand set-up for the multiplier and divider
    assign sgn = (f3 == F3_DIV) || (f3 == F3_REM);
    assign sa  = sgn & a[31];
    assign sb  = sgn & b[31];

    always_comb begin
        o_item          = it;
        o_item.neg_q    = sa ^ sb;
        o_item.neg_r    = sa;
        o_item.div_zero = (b == 32'd0);
    end

    assign o_mul.a = {(f3 == F3_MULH || f3 == F3_MULHSU) & a[31], a};
    assign o_mul.b = {(f3 == F3_MULH) & b[31], b};

    assign o_div.rem = '0;
    assign o_div.quo = sa ? (32'd0 - a) : a;
    assign o_div.dvs = sb ? (32'd0 - b) : b;

endmodule

/* rtl/rvx_div_step.sv */
// One divider slice: DIV_BITS restoring steps of an unsigned 32-bit division.
module rvx_div_step (
    input  rvx_pkg::t_div_state i_state,
    output rvx_pkg::t_div_state o_state
);
    import rvx_pkg::*;

    logic [31:0] rem, quo;
    logic [32:0] sh;
    logic        bit_q;

    // Shift in one dividend bit per step, subtract where it fits
    always_comb begin
        rem   = i_state.rem;
        quo   = i_state.quo;
        sh    = '0;
        bit_q = 1'b0;
        for (int j = 0; j < DIV_BITS; j++) begin
            sh    = {rem, quo[31]};
            bit_q = (sh >= {1'b0, i_state.dvs});
            rem   = bit_q ? 32'(sh - {1'b0, i_state.dvs}) : sh[31:0];
            quo   = {quo[30:0], bit_q};
        end
        o_state.rem = rem;
        o_state.quo = quo;
        o_state.dvs = i_state.dvs;
    end

endmodule

/* bench/tb_rv32im_execute_unit.sv */
// Self-checking testbench for the pipelined RV32IM execute unit.
`timescale 1ns / 100ps

module tb_rv32im_execute_unit;
    import rvx_pkg::*;

    typedef struct packed {
        logic        rd_write;
        logic [4:0]  rd_index;
        logic [31:0] rd_value;
        logic [31:0] next_pc;
        logic [1:0]  mem_op;
        logic [1:0]  access_size;
        logic        load_unsigned;
        logic [31:0] mem_address;
        logic [31:0] store_data;
        logic [1:0]  fault;
    } t_outcome;

    localparam logic [2:0] F3_MULHU = 3'd3;
    localparam logic [2:0] F3_REMU  = 3'd7;
    localparam logic [2:0] F3_CSRRS = 3'd2;
    localparam int PIPE_DEPTH = DIV_STAGES + 2;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_instr;
    logic [31:0] i_pc;
    logic [31:0] i_rs1_value;
    logic [31:0] i_rs2_value;
    logic        o_valid;
    logic        i_stall;
    logic        o_rd_write;
    logic [4:0]  o_rd_index;
    logic [31:0] o_rd_value;
    logic [31:0] o_next_pc;
    logic [1:0]  o_mem_op;
    logic [1:0]  o_access_size;
    logic        o_load_unsigned;
    logic [31:0] o_mem_address;
    logic [31:0] o_store_data;
    logic [1:0]  o_fault;

    t_outcome expected_q[$];
    int       error_count;
    bit       sender_calm;
    bit       receiver_calm;
    bit       hold_off_go;
    bit       hold_off;

    rv32im_execute_unit i_dut (.*);

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Signed less-than on raw words
    function automatic bit lt_s(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // M extension result
    function automatic logic [31:0] muldiv_result(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
        logic [63:0] prod;
        logic [31:0] ma, mb, q, r;
        case (f3)
            F3_MUL:    prod = a * b;
            F3_MULH:   prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            F3_MULHSU: prod = {{32{a[31]}}, a} * {32'd0, b};
            F3_MULHU:  prod = {32'd0, a} * {32'd0, b};
            default:   prod = '0;
        endcase
        if (f3 == F3_MUL) return prod[31:0];
        if (f3 inside {F3_MULH, F3_MULHSU, F3_MULHU}) return prod[63:32];
        if (b == 0) return 32'd0;
        if (f3 == F3_DIVU) return a / b;
        if (f3 == F3_REMU) return a % b;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        r = ma % mb;
        if (f3 == F3_DIV) return (a[31] != b[31]) ? -q : q;
        return a[31] ? -r : r;
    endfunction

    // Work out the architectural outcome of one instruction
    function automatic t_outcome execute_instr(logic [31:0] ins, logic [31:0] pc,
                                               logic [31:0] a, logic [31:0] b);
        t_outcome   o;
        logic [6:0] opc, f7;
        logic [2:0] f3;
        logic [4:0] sh;
        logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
        logic [11:0] csr;
        bit illegal, take;
        opc = ins[6:0];
        f3 = ins[14:12];
        f7 = ins[31:25];
        sh = ins[24:20];
        csr = ins[31:20];
        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        imm_u = {ins[31:12], 12'd0};
        o = '0;
        o.rd_index = ins[11:7];
        o.next_pc = pc + 4;
        illegal = 0;
        take = 0;
        case (opc)
            OP_LUI:   begin o.rd_write = 1; o.rd_value = imm_u; end
            OP_AUIPC: begin o.rd_write = 1; o.rd_value = pc + imm_u; end
            OP_JAL: begin
                o.rd_write = 1; o.rd_value = pc + 4; o.next_pc = pc + imm_j;
            end
            OP_JALR: begin
                if (f3 != 0) illegal = 1;
                else begin
                    o.rd_write = 1; o.rd_value = pc + 4;
                    o.next_pc = (a + imm_i) & 32'hffff_fffe;
                end
            end
            OP_BRANCH: begin
                case (f3)
                    3'd0: take = a == b;
                    3'd1: take = a != b;
                    3'd4: take = lt_s(a, b);
                    3'd5: take = !lt_s(a, b);
                    3'd6: take = a < b;
                    3'd7: take = a >= b;
                    default: illegal = 1;
                endcase
                if (take) o.next_pc = pc + imm_b;
            end
            OP_LOAD: begin
                if (f3 == 3 || f3 > 5) illegal = 1;
                else begin
                    o.mem_op = MEM_LOAD; o.access_size = f3[1:0];
                    o.load_unsigned = f3[2]; o.mem_address = a + imm_i;
                end
            end
            OP_STORE: begin
                if (f3 > 2) illegal = 1;
                else begin
                    o.mem_op = MEM_STORE; o.access_size = f3[1:0];
                    o.mem_address = a + imm_s; o.store_data = b;
                end
            end
            OP_IMM: begin
                o.rd_write = 1;
                case (f3)
                    3'd0: o.rd_value = a + imm_i;
                    3'd2: o.rd_value = {31'd0, lt_s(a, imm_i)};
                    3'd3: o.rd_value = {31'd0, a < imm_i};
                    3'd4: o.rd_value = a ^ imm_i;
                    3'd6: o.rd_value = a | imm_i;
                    3'd7: o.rd_value = a & imm_i;
                    3'd1: if (f7 != F7_BASE) illegal = 1; else o.rd_value = a << sh;
                    default: begin
                        if (f7 == F7_BASE) o.rd_value = a >> sh;
                        else if (f7 == F7_ALT) o.rd_value = $signed(a) >>> sh;
                        else illegal = 1;
                    end
                endcase
            end
            OP_REG: begin
                o.rd_write = 1;
                if (f7 == F7_MULDIV) o.rd_value = muldiv_result(f3, a, b);
                else if (f7 == F7_ALT) begin
                    if (f3 == 0) o.rd_value = a - b;
                    else if (f3 == 5) o.rd_value = $signed(a) >>> b[4:0];
                    else illegal = 1;
                end else if (f7 != F7_BASE) illegal = 1;
                else begin
                    case (f3)
                        3'd0: o.rd_value = a + b;
                        3'd1: o.rd_value = a << b[4:0];
                        3'd2: o.rd_value = {31'd0, lt_s(a, b)};
                        3'd3: o.rd_value = {31'd0, a < b};
                        3'd4: o.rd_value = a ^ b;
                        3'd5: o.rd_value = a >> b[4:0];
                        3'd6: o.rd_value = a | b;
                        default: o.rd_value = a & b;
                    endcase
                end
            end
            OP_SYSTEM: begin
                if (f3 != 0 && !(f3 == F3_CSRRS &&
                    ((csr >= CSR_CYC_LO && csr <= CSR_CYC_HI) ||
                     (csr >= CSR_CYCH_LO && csr <= CSR_CYCH_HI))))
                    illegal = 1;
            end
            default: illegal = 1;
        endcase
        if (illegal) begin
            o = '0;
            o.rd_index = ins[11:7];
            o.next_pc = pc + 4;
            o.fault = FAULT_ILLEGAL;
        end else if (o.mem_op != MEM_NONE &&
                     ((o.access_size == SIZE_HALF && o.mem_address[0]) ||
                      (o.access_size == SIZE_WORD && o.mem_address[1:0] != 0))) begin
            o.mem_op = MEM_NONE;
            o.fault = FAULT_ALIGN;
        end
        if (!o.rd_write) o.rd_value = '0;
        return o;
    endfunction

    // Offer one beat and hold it until accepted; valid stays up for the next caller
    task automatic send_instr(logic [31:0] ins, logic [31:0] pc, logic [31:0] a, logic [31:0] b);
        while (!sender_calm && $urandom_range(99) < 7) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_instr <= ins;
        i_pc <= pc;
        i_rs1_value <= a;
        i_rs2_value <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_q.push_back(execute_instr(ins, pc, a, b));
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    // Build a mostly well-formed instruction with random fields
    function automatic logic [31:0] rnd_instr();
        logic [31:0] ins;
        logic [6:0] ops[10] = '{OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH, OP_LOAD,
                                OP_STORE, OP_IMM, OP_REG, OP_SYSTEM};
        ins = $urandom;
        if ($urandom_range(19) == 0) return ins;
        ins[6:0] = ops[$urandom_range(9)];
        if (ins[6:0] == OP_REG || (ins[6:0] == OP_IMM && ins[13:12] == 2'b01)) begin
            case ($urandom_range(9))
                0: ; // leave funct7 random
                1, 2: ins[31:25] = F7_ALT;
                3, 4, 5: ins[31:25] = F7_MULDIV;
                default: ins[31:25] = F7_BASE;
            endcase
        end
        if (ins[6:0] == OP_SYSTEM && $urandom_range(1)) begin
            ins[14:12] = F3_CSRRS;
            ins[31:20] = $urandom_range(1) ? CSR_CYC_LO + 12'($urandom_range(3))
                                           : CSR_CYCH_LO + 12'($urandom_range(3));
        end
        return ins;
    endfunction

    // Count out the long hold-off once it is requested
    initial begin
        hold_off <= 1'b0;
        wait (hold_off_go);
        @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (60) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    // Drive stall at random, with calm stretches and one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else if (hold_off) i_stall <= 1'b1;
        else i_stall <= !receiver_calm && $urandom_range(99) < 7;
    end

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_outcome want, got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_rd_write, o_rd_index, o_rd_value, o_next_pc, o_mem_op, o_access_size,
                    o_load_unsigned, o_mem_address, o_store_data, o_fault};
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat %h", $realtime, got);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
                    if (got.rd_value !== want.rd_value)
                        $display("  rd_value expected %h actual %h", want.rd_value, got.rd_value);
                    if (got.next_pc !== want.next_pc)
                        $display("  next_pc expected %h actual %h", want.next_pc, got.next_pc);
                    if (got.fault !== want.fault)
                        $display("  fault expected %0d actual %0d", want.fault, got.fault);
                end
            end
        end
    end

    task automatic test_directed_alu();
        send_instr({12'hfff, 5'd1, 3'd0, 5'd0, OP_IMM}, 32'h0, 32'hffff_ffff, 0);
        send_instr({7'h00, 5'd31, 5'd1, 3'd1, 5'd3, OP_IMM}, 32'h4, 32'h1, 0);
        send_instr({F7_ALT, 5'd31, 5'd1, 3'd5, 5'd3, OP_IMM}, 32'h8, 32'h8000_0000, 0);
        send_instr({F7_ALT, 5'd2, 5'd1, 3'd5, 5'd4, OP_REG}, 32'hc, 32'h8000_0000, 32'hffff_ffe4);
        send_instr({F7_ALT, 5'd2, 5'd1, 3'd0, 5'd0, OP_REG}, 32'hfffffffc, 32'h0, 32'h1);
        send_instr({20'hfffff, 5'd5, OP_LUI}, 32'h10, 0, 0);
        send_instr({20'h80000, 5'd6, OP_AUIPC}, 32'hffff_f000, 0, 0);
    endtask

    task automatic test_directed_muldiv();
        send_instr({F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd7, OP_REG}, 0, 32'h8000_0000, 32'hffff_ffff);
        send_instr({F7_MULDIV, 5'd2, 5'd1, F3_REM, 5'd7, OP_REG}, 0, 32'h8000_0000, 32'hffff_ffff);
        send_instr({F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd7, OP_REG}, 0, 32'h1234, 0);
        send_instr({F7_MULDIV, 5'd2, 5'd1, F3_REMU, 5'd7, OP_REG}, 0, 32'h1234, 0);
        send_instr({F7_MULDIV, 5'd2, 5'd1, F3_MULH, 5'd7, OP_REG}, 0, 32'h8000_0000, 32'h8000_0000);
        send_instr({F7_MULDIV, 5'd2, 5'd1, F3_MULHSU, 5'd7, OP_REG}, 0, 32'hffff_ffff, 32'hffff_ffff);
        send_instr({F7_MULDIV, 5'd2, 5'd1, F3_MULHU, 5'd7, OP_REG}, 0, 32'hffff_ffff, 32'hffff_ffff);
    endtask

    task automatic test_directed_control();
        send_instr({1'b1, 10'h3ff, 1'b1, 8'hff, 5'd1, OP_JAL}, 32'h100, 0, 0);
        send_instr({12'h7ff, 5'd1, 3'd0, 5'd1, OP_JALR}, 0, 32'hffff_ffff, 0);
        send_instr({1'b1, 6'h3f, 5'd2, 5'd1, 3'd4, 4'hf, 1'b1, OP_BRANCH}, 32'h200, 32'h8000_0000, 1);
        send_instr({12'h000, 5'd1, 3'd1, 5'd1, OP_JALR}, 0, 0, 0);
        send_instr({12'h001, 5'd1, 3'd2, 5'd3, OP_LOAD}, 0, 32'h0, 0);
        send_instr({12'h001, 5'd1, 3'd5, 5'd3, OP_LOAD}, 0, 32'h1, 0);
        send_instr({7'h7f, 5'd2, 5'd1, 3'd1, 5'h1f, OP_STORE}, 0, 32'h0, 32'hdead_beef);
        send_instr({12'hc82, 5'd0, F3_CSRRS, 5'd9, OP_SYSTEM}, 0, 0, 0);
        send_instr({12'hc83, 5'd0, F3_CSRRS, 5'd9, OP_SYSTEM}, 0, 0, 0);
        send_instr({12'hfff, 5'd0, 3'd0, 5'd0, OP_SYSTEM}, 0, 0, 0);
        send_instr(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            sender_calm = (n % 400) >= 300;
            receiver_calm = (n % 500) < 80;
            send_instr(rnd_instr(), rnd_word(), rnd_word(), rnd_word());
        end
        sender_calm = 0;
        receiver_calm = 0;
    endtask

    // Stall the output for a long stretch while items keep arriving
    task automatic test_backpressure();
        sender_calm = 1;
        hold_off_go = 1;
        for (int n = 0; n < 40; n++)
            send_instr(rnd_instr(), $urandom, $urandom, $urandom);
        sender_calm = 0;
    endtask

    initial begin
        error_count = 0;
        sender_calm = 0;
        receiver_calm = 0;
        hold_off_go = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_instr = '0;
        i_pc = '0;
        i_rs1_value = '0;
        i_rs2_value = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_alu();
        test_directed_muldiv();
        test_directed_control();
        test_backpressure();
        test_random(1650);
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Timeout
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
